// File: rtl/bfr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitstream field reader package
// Request and status codes and default sizes shared by the reader's files.
// ----------------------------------------------------------------------------
package bfr_pkg;

    localparam int BFR_STORE_BYTES    = 4096;
    localparam int BFR_MAX_FIELD_BITS = 25;

    localparam int BFR_REQ_W    = 3;
    localparam int BFR_BYTE_W   = 8;
    localparam int BFR_COUNT_W  = 15;
    localparam int BFR_REF_W    = 3;
    localparam int BFR_STATUS_W = 2;
    localparam int BFR_LEFT_W   = 16;

    typedef enum logic [BFR_REQ_W-1:0] {
        REQ_LOAD  = 3'd0,
        REQ_READ  = 3'd1,
        REQ_SHOW  = 3'd2,
        REQ_SKIP  = 3'd3,
        REQ_ALIGN = 3'd4
    } req_t;

    typedef enum logic [BFR_STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_FULL  = 2'd2,
        ST_LONG  = 2'd3
    } status_t;

endpackage

// File: rtl/bfr_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitstream field reader request channel
// Valid/ready channel that carries one request item.
// ----------------------------------------------------------------------------
interface bfr_req_if
    import bfr_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [BFR_REQ_W-1:0]   req_type;
    logic [BFR_BYTE_W-1:0]  byte_in;
    logic [BFR_COUNT_W-1:0] n_bits;
    logic [BFR_REF_W-1:0]   align_reference;

    modport source (
        output valid, req_type, byte_in, n_bits, align_reference,
        input  ready
    );

    modport sink (
        input  valid, req_type, byte_in, n_bits, align_reference,
        output ready
    );
endinterface

// File: rtl/bfr_res_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitstream field reader result channel
// Valid/ready channel that carries one result item.
// ----------------------------------------------------------------------------
interface bfr_res_if
    import bfr_pkg::*;
#(
    parameter int VALUE_W = BFR_MAX_FIELD_BITS
) ();
    logic                    valid;
    logic                    ready;
    logic [VALUE_W-1:0]      field_value;
    logic [BFR_STATUS_W-1:0] status;
    logic [BFR_LEFT_W-1:0]   bits_left;

    modport source (
        output valid, field_value, status, bits_left,
        input  ready
    );

    modport sink (
        input  valid, field_value, status, bits_left,
        output ready
    );
endinterface

// File: rtl/bfr_window_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitstream field reader window store
// Byte store kept as one copy per window lane, so that consecutive bytes
// are read together, each through a registered read port of its own lane.
// ----------------------------------------------------------------------------
module bfr_window_ram
    import bfr_pkg::*;
#(
    parameter int DEPTH = BFR_STORE_BYTES,
    parameter int LANES = 4,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [ADDR_W-1:0]             wr_addr,
    input  logic [7:0]                    wr_data,
    input  logic                          rd_en,
    input  logic [LANES-1:0][ADDR_W-1:0]  rd_addr,
    output logic [LANES*8-1:0]            rd_data
);

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        logic [7:0] mem [DEPTH];
        logic [7:0] rd_q;

        always_ff @(posedge clk)
        begin
            if (wr_en)
            begin
                mem[wr_addr] <= wr_data;
            end
            if (rd_en)
            begin
                rd_q <= mem[rd_addr[g]];
            end
        end

        assign rd_data[(LANES-1-g)*8 +: 8] = rd_q;
    end

endmodule

// File: rtl/bitstream_field_reader_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitstream field reader
// Reads bit fields most significant bit first from a ring of loaded bytes.
// ----------------------------------------------------------------------------
// The req channel takes one request item per cycle while req.ready is high:
// load a byte, read, show or skip n_bits bits, or align the unread bit
// count to align_reference modulo 8. Every request gives exactly one item
// on the res channel, in request order, with the field value, a status code
// and the unread bit count after the request. Pointers and the bit count
// update in the cycle a request is taken; a read of the byte window is
// issued at the same edge and the field is extracted from the registered
// window data as the item moves from the extract stage to the output
// register. One request per cycle is sustained while res is taken. The
// byte store holds one copy per window lane so that all window bytes come
// from their own read port. Reset clears the pointers and bit count at
// once; there is no clearing pass, since a field only uses loaded bits.
// When res stalls, one result waits in the output register and one more in
// the extract stage; req.ready then drops until the output moves on.
// ----------------------------------------------------------------------------
module bitstream_field_reader_unit
    import bfr_pkg::*;
#(
    parameter int STORE_BYTES = BFR_STORE_BYTES
) (
    input  logic      clk,
    input  logic      rst_n,
    bfr_req_if.sink   req,
    bfr_res_if.source res
);

    localparam int MAX_FIELD_BITS = BFR_MAX_FIELD_BITS;
    localparam int IDX_W   = $clog2(STORE_BYTES);
    localparam int BITS_MAX = STORE_BYTES * 8;
    localparam int BA_W    = $clog2(BITS_MAX + 1);
    localparam int CW      = (BA_W > BFR_COUNT_W) ? BA_W : BFR_COUNT_W;
    localparam int LANES   = (MAX_FIELD_BITS + 14) / 8;
    localparam int WIN_W   = LANES * 8;
    localparam int LEN_W   = $clog2(MAX_FIELD_BITS + 1);
    localparam int SH_W    = $clog2(WIN_W + 1);

    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;
    logic [2:0]       pos_reg, pos_next;
    logic [BA_W-1:0]  avail_reg, avail_next;

    logic                    s1_valid_reg;
    logic                    s1_take_reg, s1_take_next;
    logic [2:0]              s1_pos_reg;
    logic [LEN_W-1:0]        s1_len_reg;
    status_t                 s1_status_reg, s1_status_next;
    logic [BFR_LEFT_W-1:0]   s1_left_reg, s1_left_next;

    logic                        out_valid_reg;
    logic [MAX_FIELD_BITS-1:0]   out_value_reg, out_value_next;
    status_t                     out_status_reg;
    logic [BFR_LEFT_W-1:0]       out_left_reg;

    logic accept;
    logic out_free;
    logic s1_move;

    logic                         wr_en;
    logic [LANES-1:0][IDX_W-1:0]  rd_addr;
    logic [WIN_W-1:0]             window;

    logic [CW-1:0]    n_ext;
    logic [CW-1:0]    avail_ext;
    logic [CW-1:0]    cons;
    logic             do_cons;
    logic [CW:0]      total;
    logic [CW:0]      left_ext;
    logic [IDX_W:0]   adv;
    logic [IDX_W:0]   idx_sum;
    logic [BA_W:0]    occ_bits;
    logic [2:0]       align_a;
    logic [3:0]       align_need;

    logic [WIN_W-1:0] aligned;
    logic [WIN_W-1:0] shifted;
    logic [SH_W-1:0]  rshift;

    assign out_free  = !out_valid_reg || res.ready;
    assign req.ready = !s1_valid_reg || out_free;
    assign accept    = req.valid && req.ready;
    assign s1_move   = s1_valid_reg && out_free;

    always_comb
    begin
        rd_idx_next    = rd_idx_reg;
        wr_idx_next    = wr_idx_reg;
        pos_next       = pos_reg;
        avail_next     = avail_reg;
        s1_take_next   = 1'b0;
        s1_status_next = ST_OK;
        wr_en          = 1'b0;
        do_cons        = 1'b0;
        cons           = '0;
        n_ext          = CW'(req.n_bits);
        avail_ext      = CW'(avail_reg);
        align_a        = 3'(req.align_reference - avail_reg[2:0]);
        align_need     = 4'(4'd8 - {1'b0, align_a});
        occ_bits       = (BA_W+1)'(avail_reg) + (BA_W+1)'(3'd7 - pos_reg);

        unique case (req.req_type)
            REQ_LOAD:
            begin
                if ((occ_bits >> 3) >= (BA_W+1)'(STORE_BYTES))
                begin
                    s1_status_next = ST_FULL;
                end
                else
                begin
                    wr_en      = accept;
                    avail_next = BA_W'(avail_reg + BA_W'(8));
                    if (wr_idx_reg == IDX_W'(STORE_BYTES - 1))
                    begin
                        wr_idx_next = '0;
                    end
                    else
                    begin
                        wr_idx_next = IDX_W'(wr_idx_reg + 1'b1);
                    end
                end
            end
            REQ_READ, REQ_SHOW:
            begin
                if (n_ext == '0)
                begin
                    s1_status_next = ST_OK;
                end
                else if (n_ext > CW'(MAX_FIELD_BITS))
                begin
                    s1_status_next = ST_LONG;
                end
                else if (n_ext > avail_ext)
                begin
                    s1_status_next = ST_SHORT;
                end
                else
                begin
                    s1_take_next = 1'b1;
                    do_cons      = (req.req_type == REQ_READ);
                    cons         = n_ext;
                end
            end
            REQ_SKIP:
            begin
                if (n_ext > avail_ext)
                begin
                    s1_status_next = ST_SHORT;
                end
                else
                begin
                    do_cons = 1'b1;
                    cons    = n_ext;
                end
            end
            REQ_ALIGN:
            begin
                if (align_a != 3'd0)
                begin
                    if (CW'(align_need) > avail_ext)
                    begin
                        s1_status_next = ST_SHORT;
                    end
                    else
                    begin
                        do_cons = 1'b1;
                        cons    = CW'(align_need);
                    end
                end
            end
            default:
            begin
                s1_status_next = ST_OK;
            end
        endcase

        total   = (CW+1)'(cons) + (CW+1)'(3'd7 - pos_reg);
        adv     = (IDX_W+1)'(total >> 3);
        idx_sum = (IDX_W+1)'(rd_idx_reg) + adv;
        if (do_cons)
        begin
            if (idx_sum >= (IDX_W+1)'(STORE_BYTES))
            begin
                rd_idx_next = IDX_W'(idx_sum - (IDX_W+1)'(STORE_BYTES));
            end
            else
            begin
                rd_idx_next = IDX_W'(idx_sum);
            end
            pos_next   = 3'(3'd7 - total[2:0]);
            avail_next = BA_W'(avail_ext - cons);
        end

        left_ext     = (CW+1)'(avail_next);
        s1_left_next = left_ext[BFR_LEFT_W-1:0];
    end

    always_comb
    begin
        logic [IDX_W:0] lane_sum;
        for (int j = 0; j < LANES; j++)
        begin
            lane_sum = (IDX_W+1)'(rd_idx_reg) + (IDX_W+1)'(j);
            if (lane_sum >= (IDX_W+1)'(STORE_BYTES))
            begin
                rd_addr[j] = IDX_W'(lane_sum - (IDX_W+1)'(STORE_BYTES));
            end
            else
            begin
                rd_addr[j] = IDX_W'(lane_sum);
            end
        end
    end

    bfr_window_ram #(
        .DEPTH (STORE_BYTES),
        .LANES (LANES)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx_reg),
        .wr_data (req.byte_in),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (window)
    );

    always_comb
    begin
        aligned = window << (3'd7 - s1_pos_reg);
        rshift  = SH_W'(WIN_W) - SH_W'(s1_len_reg);
        shifted = aligned >> rshift;
        if (s1_take_reg)
        begin
            out_value_next = shifted[MAX_FIELD_BITS-1:0];
        end
        else
        begin
            out_value_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg    <= '0;
            wr_idx_reg    <= '0;
            pos_reg       <= 3'd7;
            avail_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                rd_idx_reg <= rd_idx_next;
                wr_idx_reg <= wr_idx_next;
                pos_reg    <= pos_next;
                avail_reg  <= avail_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_move)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_take_reg   <= s1_take_next;
            s1_pos_reg    <= pos_reg;
            s1_len_reg    <= LEN_W'(req.n_bits);
            s1_status_reg <= s1_status_next;
            s1_left_reg   <= s1_left_next;
        end
        if (s1_move)
        begin
            out_value_reg  <= out_value_next;
            out_status_reg <= s1_status_reg;
            out_left_reg   <= s1_left_reg;
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.field_value = out_value_reg;
    assign res.status      = out_status_reg;
    assign res.bits_left   = out_left_reg;

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !req.ready |-> (s1_valid_reg && out_valid_reg))
        else $error("Request channel stalled with a free pipeline slot.");

    a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("Accepted item did not reach the extract stage.");

    a_avail_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (BA_W+1)'(avail_reg) <= (BA_W+1)'(BITS_MAX))
        else $error("Available bit count exceeds the store size.");

    a_index_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        ((IDX_W+1)'(rd_idx_reg) < (IDX_W+1)'(STORE_BYTES))
        && ((IDX_W+1)'(wr_idx_reg) < (IDX_W+1)'(STORE_BYTES)))
        else $error("Store index out of range.");

endmodule

// File: bench/field_result_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitstream field reader result monitor
// Watches the request and result channels of the reader. Each accepted
// request item is run through a local model of the byte ring, read pointer
// and bit count to work out its field value, status and unread bit count.
// Each accepted result item is compared field by field with the oldest
// expected result. Mismatches and results that nobody expects are counted
// and reported to the testbench top.
// ----------------------------------------------------------------------------
module field_result_monitor
    import bfr_pkg::*;
#(
    parameter int STORE_BYTES    = BFR_STORE_BYTES,
    parameter int MAX_FIELD_BITS = BFR_MAX_FIELD_BITS
) (
    input  logic clk,
    input  logic rst_n,
    bfr_req_if   req,
    bfr_res_if   res,
    output int   fail_count,
    output int   pending
);

    typedef struct packed {
        logic [MAX_FIELD_BITS-1:0] value;
        status_t                   status;
        logic [BFR_LEFT_W-1:0]     left;
    } field_result_t;

    logic [BFR_BYTE_W-1:0] byte_ring [STORE_BYTES];
    int unsigned           head_byte;
    int unsigned           tail_byte;
    int unsigned           bit_pos;
    int unsigned           bits_avail;
    field_result_t         expected_fields [$];

    function automatic logic [MAX_FIELD_BITS-1:0] peek_field(input int unsigned n);
        logic [MAX_FIELD_BITS-1:0] v;
        int unsigned               idx;
        int unsigned               pos;
        v   = '0;
        idx = head_byte;
        pos = bit_pos;
        for (int k = 0; k < n; k++)
        begin
            v = {v[MAX_FIELD_BITS-2:0], byte_ring[idx][pos]};
            if (pos == 0)
            begin
                pos = 7;
                idx = (idx + 1) % STORE_BYTES;
            end
            else
            begin
                pos = pos - 1;
            end
        end
        return v;
    endfunction

    task automatic consume_bits(input int unsigned n);
        int unsigned total;
        total      = (7 - bit_pos) + n;
        head_byte  = (head_byte + total / 8) % STORE_BYTES;
        bit_pos    = 7 - (total % 8);
        bits_avail = bits_avail - n;
    endtask

    task automatic model_request(
        input  logic [BFR_REQ_W-1:0]   kind,
        input  logic [BFR_BYTE_W-1:0]  data,
        input  logic [BFR_COUNT_W-1:0] count,
        input  logic [BFR_REF_W-1:0]   anchor,
        output field_result_t          outcome
    );
        int unsigned n;
        int unsigned misalign;
        n               = count;
        outcome.value   = '0;
        outcome.status  = ST_OK;
        unique case (kind)
            REQ_LOAD:
            begin
                if ((bits_avail + 7 - bit_pos) / 8 >= STORE_BYTES)
                begin
                    outcome.status = ST_FULL;
                end
                else
                begin
                    byte_ring[tail_byte] = data;
                    tail_byte            = (tail_byte + 1) % STORE_BYTES;
                    bits_avail           = bits_avail + 8;
                end
            end
            REQ_READ, REQ_SHOW:
            begin
                if (n == 0)
                begin
                    outcome.status = ST_OK;
                end
                else if (n > MAX_FIELD_BITS)
                begin
                    outcome.status = ST_LONG;
                end
                else if (n > bits_avail)
                begin
                    outcome.status = ST_SHORT;
                end
                else
                begin
                    outcome.value = peek_field(n);
                    if (kind == REQ_READ)
                    begin
                        consume_bits(n);
                    end
                end
            end
            REQ_SKIP:
            begin
                if (n > bits_avail)
                begin
                    outcome.status = ST_SHORT;
                end
                else
                begin
                    consume_bits(n);
                end
            end
            REQ_ALIGN:
            begin
                misalign = (anchor - bits_avail) & 7;
                if (misalign != 0)
                begin
                    if (8 - misalign > bits_avail)
                    begin
                        outcome.status = ST_SHORT;
                    end
                    else
                    begin
                        consume_bits(8 - misalign);
                    end
                end
            end
            default:
            begin
            end
        endcase
        outcome.left = BFR_LEFT_W'(bits_avail);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        field_result_t want;
        field_result_t fresh;
        int            bad;
        if (!rst_n)
        begin
            head_byte  = 0;
            tail_byte  = 0;
            bit_pos    = 7;
            bits_avail = 0;
            expected_fields.delete();
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            bad = 0;
            if (res.valid && res.ready)
            begin
                if (expected_fields.size() == 0)
                begin
                    $display("%0t: unexpected result item: value %h status %0d left %0d",
                             $time, res.field_value, res.status, res.bits_left);
                    bad++;
                end
                else
                begin
                    want = expected_fields.pop_front();
                    if (res.field_value !== want.value || res.status !== want.status
                        || res.bits_left !== want.left)
                    begin
                        if (res.field_value !== want.value)
                        begin
                            $display("%0t: field_value expected %h actual %h",
                                     $time, want.value, res.field_value);
                        end
                        if (res.status !== want.status)
                        begin
                            $display("%0t: status expected %0d actual %0d",
                                     $time, want.status, res.status);
                        end
                        if (res.bits_left !== want.left)
                        begin
                            $display("%0t: bits_left expected %0d actual %0d",
                                     $time, want.left, res.bits_left);
                        end
                        bad++;
                    end
                end
            end
            if (req.valid && req.ready)
            begin
                model_request(req.req_type, req.byte_in, req.n_bits,
                              req.align_reference, fresh);
                expected_fields.push_back(fresh);
            end
            fail_count <= fail_count + bad;
            pending    <= expected_fields.size();
        end
    end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bitstream field reader testbench
// Drives request items into the reader: a directed opening over the edge
// cases, random request mixes under three patterns of sender and receiver
// idling, one long receiver stall, a skip sweep and a long run of loads.
// The result monitor predicts and checks every result item.
// ----------------------------------------------------------------------------
module testbench;
    import bfr_pkg::*;

    localparam int                   HOLD_CYCLES    = 64;
    localparam int                   SETTLE_CYCLES  = 8;
    localparam int                   FILL_BYTES     = 256;
    localparam logic [BFR_REQ_W-1:0] REQ_UNUSED_MAX = '1;
    localparam logic [BFR_REQ_W-1:0] REQ_UNUSED_MIN = BFR_REQ_W'(REQ_ALIGN + 1);

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   sink_idle_pct;
    logic hold_off;
    int   fail_count;
    int   pending;

    bfr_req_if req_ch ();
    bfr_res_if res_ch ();

    bitstream_field_reader_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    field_result_monitor u_monitor (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .res        (res_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        res_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off = 1'b0;
            end
            res_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    task automatic issue_request(
        input logic [BFR_REQ_W-1:0]   kind,
        input logic [BFR_BYTE_W-1:0]  data,
        input logic [BFR_COUNT_W-1:0] count,
        input logic [BFR_REF_W-1:0]   anchor
    );
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.req_type        <= kind;
        req_ch.byte_in         <= data;
        req_ch.n_bits          <= count;
        req_ch.align_reference <= anchor;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic issue_random_request();
        int unsigned             pick;
        logic [BFR_COUNT_W-1:0]  n;
        logic [BFR_BYTE_W-1:0]   data;
        logic [BFR_REF_W-1:0]    anchor;
        pick   = $urandom_range(99);
        data   = BFR_BYTE_W'($urandom);
        anchor = BFR_REF_W'($urandom);
        if ($urandom_range(19) == 0)
        begin
            n = BFR_COUNT_W'($urandom);
        end
        else
        begin
            n = BFR_COUNT_W'($urandom_range(BFR_MAX_FIELD_BITS));
        end
        if (pick < 48)
        begin
            issue_request(REQ_LOAD, data, n, anchor);
        end
        else if (pick < 70)
        begin
            issue_request(REQ_READ, data, n, anchor);
        end
        else if (pick < 80)
        begin
            issue_request(REQ_SHOW, data, n, anchor);
        end
        else if (pick < 89)
        begin
            issue_request(REQ_SKIP, data, n, anchor);
        end
        else if (pick < 96)
        begin
            issue_request(REQ_ALIGN, data, n, anchor);
        end
        else
        begin
            issue_request(BFR_REQ_W'($urandom_range(REQ_UNUSED_MAX, REQ_UNUSED_MIN)),
                          data, n, anchor);
        end
    endtask

    task automatic wait_for_results();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
    endtask

    initial
    begin
        int k;
        int pass;
        rst_n                   = 1'b0;
        req_ch.valid           <= 1'b0;
        req_ch.req_type        <= REQ_LOAD;
        req_ch.byte_in         <= '0;
        req_ch.n_bits          <= '0;
        req_ch.align_reference <= '0;
        src_idle_pct            = 31;
        sink_idle_pct           = 52;
        hold_off                = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        issue_request(REQ_READ, 8'h00, 15'd1, 3'd0);
        issue_request(REQ_SHOW, 8'h00, 15'd0, 3'd0);
        issue_request(REQ_SKIP, 8'h00, 15'd0, 3'd0);
        issue_request(REQ_ALIGN, 8'h00, 15'd0, 3'd3);
        issue_request(REQ_ALIGN, 8'h00, 15'd0, 3'd0);
        issue_request(REQ_READ, 8'h00, 15'd26, 3'd0);
        issue_request(REQ_SHOW, 8'h00, '1, 3'd7);
        issue_request(REQ_SKIP, 8'h00, '1, 3'd7);
        issue_request(REQ_LOAD, 8'hFF, 15'd0, 3'd0);
        issue_request(REQ_LOAD, 8'h00, 15'd0, 3'd0);
        issue_request(REQ_LOAD, 8'hA5, 15'd0, 3'd0);
        issue_request(REQ_LOAD, 8'h5A, 15'd0, 3'd0);
        issue_request(REQ_LOAD, 8'hFF, 15'd0, 3'd0);
        issue_request(REQ_READ, 8'h00, 15'd25, 3'd0);
        issue_request(REQ_SHOW, 8'h00, 15'd25, 3'd0);
        issue_request(REQ_SHOW, 8'h00, 15'd1, 3'd0);
        issue_request(REQ_READ, 8'h00, 15'd3, 3'd0);
        issue_request(REQ_ALIGN, 8'h00, 15'd0, 3'd0);
        issue_request(REQ_READ, 8'h00, 15'd0, 3'd0);
        issue_request(REQ_SKIP, 8'h00, 15'd4, 3'd0);
        issue_request(REQ_UNUSED_MAX, 8'hFF, '1, 3'd7);
        issue_request(REQ_ALIGN, 8'h00, 15'd0, 3'd1);
        issue_request(REQ_READ, 8'h00, 15'd1, 3'd0);
        issue_request(REQ_SHOW, 8'h00, 15'd25, 3'd0);

        for (k = 0; k < 300; k++)
        begin
            issue_random_request();
        end
        hold_off = 1'b1;
        for (k = 0; k < 280; k++)
        begin
            issue_random_request();
        end
        wait_for_results();

        src_idle_pct  = 52;
        sink_idle_pct = 31;
        for (pass = 0; pass < 2; pass++)
        begin
            for (k = BFR_COUNT_W - 1; k >= 0; k--)
            begin
                issue_request(REQ_SKIP, 8'h00, BFR_COUNT_W'(1 << k), 3'd0);
            end
        end
        for (k = 0; k < FILL_BYTES; k++)
        begin
            issue_request(REQ_LOAD, BFR_BYTE_W'($urandom), 15'd0, 3'd0);
        end
        issue_request(REQ_READ, 8'h00, 15'd3, 3'd0);
        issue_request(REQ_LOAD, 8'h3C, 15'd0, 3'd0);
        issue_request(REQ_READ, 8'h00, 15'd5, 3'd0);
        issue_request(REQ_LOAD, 8'hC3, 15'd0, 3'd0);
        issue_request(REQ_LOAD, 8'h81, 15'd0, 3'd0);
        issue_request(REQ_SHOW, 8'h00, 15'd25, 3'd0);
        issue_request(REQ_SKIP, 8'h00, '1, 3'd0);
        issue_request(REQ_READ, 8'h00, 15'd1, 3'd0);
        for (k = 0; k < 420; k++)
        begin
            issue_random_request();
        end

        src_idle_pct  = 0;
        sink_idle_pct = 0;
        for (k = 0; k < 430; k++)
        begin
            issue_random_request();
        end
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
